FILE: sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/ppa_pkg.sv
package ppa_pkg;

  // field widths of the stream payloads
  localparam int OP_W        = 2;
  localparam int IN_INDEX_W  = 3;
  localparam int IN_SIZE_W   = 16;
  localparam int STATUS_W    = 2;
  localparam int OUT_INDEX_W = 3;
  localparam int OUT_SIZE_W  = 16;
  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 24;

  // bit positions inside s_tdata and m_tdata
  localparam int IDX_LSB     = 0;
  localparam int ESZ_LSB     = IDX_LSB + IN_INDEX_W;
  localparam int REQ_LSB     = ESZ_LSB + IN_SIZE_W;
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_SZ_LSB  = OUT_IDX_LSB + OUT_INDEX_W;
  localparam int S_USED_W    = REQ_LSB + IN_SIZE_W;
  localparam int M_USED_W    = OUT_SZ_LSB + OUT_SIZE_W;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PLACED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd2;

  // configuration registers
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 4;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd2;
  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_BEST;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd6;
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic place_go;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/ppa_ram.sv
module ppa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ppa_ctrl.sv
module ppa_ctrl import ppa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd,
  output logic       s_tready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // sequencing of one item: take, for placements scan table and drain last compare, emit
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = sts.place_go ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/ppa_dp.sv
module ppa_dp import ppa_pkg::*; #(
  parameter int MAX_PARTITIONS = 8,
  parameter int SIZE_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          sts,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]     s_tuser,
  input  logic [POLICY_W-1:0] policy,
  input  logic [COUNT_W-1:0]  count,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0] m_tuser
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  // input unpacking
  logic [IN_INDEX_W-1:0]           in_index;
  logic [IN_SIZE_W-1:0]            in_esize;
  logic [IN_SIZE_W-1:0]            in_req;
  logic [SIZE_BITS+IN_SIZE_W-1:0]  esz_ext;
  logic [SIZE_BITS+IN_SIZE_W-1:0]  req_ext;
  logic [IDX_W+IN_INDEX_W-1:0]     widx_ext;
  logic                            write_ok;

  assign in_index = s_tdata[IDX_LSB +: IN_INDEX_W];
  assign in_esize = s_tdata[ESZ_LSB +: IN_SIZE_W];
  assign in_req   = s_tdata[REQ_LSB +: IN_SIZE_W];
  assign esz_ext  = {{SIZE_BITS{1'b0}}, in_esize};
  assign req_ext  = {{SIZE_BITS{1'b0}}, in_req};
  assign widx_ext = {{IDX_W{1'b0}}, in_index};
  assign write_ok = 32'(in_index) < MAX_PARTITIONS;

  // item and scan state
  logic [OP_W-1:0]           item_op;
  logic [SIZE_BITS-1:0]      req;
  logic [IDX_W-1:0]          scan_idx;
  logic [CNT_W-1:0]          remaining;
  logic                      chk_valid;
  logic [IDX_W-1:0]          chk_idx;
  logic                      found;
  logic [IDX_W-1:0]          best_idx;
  logic [SIZE_BITS-1:0]      best_size;
  logic [IDX_W-1:0]          next_ptr;
  logic [MAX_PARTITIONS-1:0] taken;
  logic [MAX_PARTITIONS-1:0] loaded;
  logic [SIZE_BITS-1:0]      rdata;

  // output register
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [OUT_INDEX_W-1:0] out_index;
  logic [OUT_SIZE_W-1:0]  out_size;

  // active entry count, saturated to the table depth
  logic [CNT_W-1:0] n_active;
  always_comb begin
    if (32'(count) > MAX_PARTITIONS) begin
      n_active = CNT_W'(MAX_PARTITIONS);
    end else begin
      n_active = CNT_W'(count);
    end
  end

  // scan start: next fit resumes at the pointer when it is in range
  logic [IDX_W-1:0] scan_start;
  always_comb begin
    if (policy == POL_NEXT && CNT_W'(next_ptr) < n_active) begin
      scan_start = next_ptr;
    end else begin
      scan_start = '0;
    end
  end

  // circular advance over the active entries
  logic             scan_wrap;
  logic [IDX_W-1:0] scan_idx_next;
  assign scan_wrap     = (CNT_W'(scan_idx) + CNT_W'(1)) == n_active;
  assign scan_idx_next = scan_wrap ? '0 : scan_idx + IDX_W'(1);

  // partition size table
  logic ram_we;
  assign ram_we = cmd.take && (s_tuser == OP_WRITE) && write_ok;

  ppa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_PARTITIONS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_ext[IDX_W-1:0]),
    .wdata (esz_ext[SIZE_BITS-1:0]),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  // compare stage: entry read last cycle against the request
  logic [SIZE_BITS-1:0] chk_size;
  logic                 usable;
  logic                 best_pol;
  logic                 take_it;
  assign chk_size = loaded[chk_idx] ? rdata : '0;
  assign usable   = chk_valid && !taken[chk_idx] && (chk_size >= req);
  assign best_pol = (policy != POL_FIRST) && (policy != POL_NEXT);
  assign take_it  = usable && (!found || (best_pol && (chk_size < best_size)));

  // status toward the controller
  assign sts.place_go  = (s_tuser == OP_PLACE) && (n_active != '0);
  assign sts.scan_last = remaining == CNT_W'(1);
  assign sts.out_free  = !out_valid || m_tready;

  // payload registers of the current item and scan
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op   <= s_tuser;
      req       <= req_ext[SIZE_BITS-1:0];
      scan_idx  <= scan_start;
      remaining <= n_active;
    end else if (cmd.scan_step) begin
      scan_idx  <= scan_idx_next;
      remaining <= remaining - CNT_W'(1);
    end
    chk_idx <= scan_idx;
    if (take_it) begin
      best_idx  <= chk_idx;
      best_size <= chk_size;
    end
  end

  // control state: compare valid, found flag, flags and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      found     <= 1'b0;
      taken     <= '0;
      loaded    <= '0;
      next_ptr  <= '0;
    end else begin
      chk_valid <= cmd.scan_step;
      if (cmd.take) begin
        found <= 1'b0;
      end else if (take_it) begin
        found <= 1'b1;
      end
      if (ram_we) begin
        loaded[widx_ext[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.take && s_tuser == OP_CLEAR) begin
        taken    <= '0;
        next_ptr <= '0;
      end else if (cmd.finish && item_op == OP_PLACE && found) begin
        taken[best_idx] <= 1'b1;
        if (policy == POL_NEXT) begin
          next_ptr <= best_idx;
        end
      end
    end
  end

  // result formatting
  logic [OUT_INDEX_W+IDX_W-1:0]     bidx_ext;
  logic [OUT_SIZE_W+SIZE_BITS-1:0]  bsz_ext;
  logic                             placed;
  logic [STATUS_W-1:0]              res_status;
  assign bidx_ext = {{OUT_INDEX_W{1'b0}}, best_idx};
  assign bsz_ext  = {{OUT_SIZE_W{1'b0}}, best_size};
  assign placed   = (item_op == OP_PLACE) && found;

  always_comb begin
    case (item_op)
      OP_PLACE: res_status = found ? STAT_PLACED : STAT_NOFIT;
      default:  res_status = STAT_DONE;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_index  <= placed ? bidx_ext[OUT_INDEX_W-1:0] : '0;
      out_size   <= placed ? bsz_ext[OUT_SIZE_W-1:0] : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(M_DATA_W - M_USED_W){1'b0}}, out_size, out_index};

endmodule

FILE: sv/partition_placement_allocator_core.sv
// channel     | direction | payload
// s_axis      | in        | tuser: opcode; tdata: entry_index, entry_size, request_size
// m_axis      | out       | tuser: status; tdata: chosen_partition, chosen_size
// apb         | in/out    | reg 0 placement_policy @0x0, reg 1 partitions_in_use @0x4
//
// a placement scans the active entries after acceptance, n being the active entry count
// (no scan when n is 0); the scan reads one entry per cycle through the single read port
// of the size memory, then drains the last compare and shows the result. writes, clears
// and other opcodes skip the scan. the next item can be taken in the cycle the result shows.
// one item is in flight; input is held off until its result moves into a free output
// register. reset clears taken flags, pointer, entry valid bits, output valid and config registers.
`include "assert_macros.svh"

module partition_placement_allocator_core import ppa_pkg::*; #(
  parameter int MAX_PARTITIONS = 8,
  parameter int SIZE_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transactions
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // entry_index, entry_size, request_size, zero pad
  input  logic [OP_W-1:0]       s_tuser,   // opcode
  // result transactions
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // chosen_partition, chosen_size, zero pad
  output logic [STATUS_W-1:0]   m_tuser,   // status
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [POLICY_W-1:0] placement_policy;
  logic [COUNT_W-1:0]  partitions_in_use;
  logic                reg_sel;
  logic                cfg_we;
  ctrl_cmd_t           cmd;
  dp_status_t          sts;

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      placement_policy  <= POLICY_RESET;
      partitions_in_use <= COUNT_RESET;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_POLICY: placement_policy  <= pwdata[POLICY_W-1:0];
        REG_COUNT:  partitions_in_use <= pwdata[COUNT_W-1:0];
        default:    placement_policy  <= placement_policy;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_POLICY: prdata = {{(APB_DATA_W - POLICY_W){1'b0}}, placement_policy};
      default:    prdata = {{(APB_DATA_W - COUNT_W){1'b0}}, partitions_in_use};
    endcase
  end

  ppa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  ppa_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .policy   (placement_policy),
    .count    (partitions_in_use),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // one item in flight at a time
  `ASSERT_NXT(a_take_blocks, clk, rst, cmd.take, !s_tready, "input taken twice in a row")
  `ASSERT_IMP(a_scan_busy, clk, rst, cmd.scan_step, !s_tready, "input ready during scan")
  // result goes only into a free output slot and shows up next cycle
  `ASSERT_IMP(a_finish_free, clk, rst, cmd.finish, (!m_tvalid || m_tready), "result overwrote output")
  `ASSERT_NXT(a_finish_out, clk, rst, cmd.finish, m_tvalid, "result not presented")

endmodule
